>>> sv/olst_pkg.sv
// Package for the ordered list engine: sizes, command and status codes,
// cell control types and the value conversion helper. No dependencies.
package olst_pkg;

   // List size and stored value width
   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;

   // Fixed port field widths
   localparam int ACT_W  = 3;
   localparam int REQ_W  = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 7;

   // Count register must hold CAPACITY itself
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Match priority tree: groups of eight cells
   localparam int GRP_SIZE = 8;
   localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   typedef enum logic [ACT_W-1:0] {
      ACT_HEAD  = 3'd0,
      ACT_TAIL  = 3'd1,
      ACT_POS   = 3'd2,
      ACT_DEL   = 3'd3,
      ACT_FIND  = 3'd4,
      ACT_CLEAR = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_POS  = 2'd2,
      STAT_MISS = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CMP  = 4'b0010,
      ST_GRP  = 4'b0100,
      ST_EXEC = 4'b1000
   } state_type;

   // What a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_LOAD = 2'd1,
      CELL_PREV = 2'd2,
      CELL_NEXT = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        occ;
   } cell_ctrl_type;

   // Sign-extend the request value, then keep VALUE_WIDTH bits
   function automatic logic [VALUE_WIDTH-1:0] held_value(input logic [REQ_W-1:0] raw);
      logic signed [63:0] ext;
      ext = 64'(signed'(raw));
      return ext[VALUE_WIDTH-1:0];
   endfunction

endpackage

>>> sv/olst_cell.sv
// One list cell: holds a single entry and its match flag, and shifts
// toward either neighbor on command. Depends on olst_pkg.
module olst_cell (
   input  logic                           clock,
   input  olst_pkg::cell_ctrl_type        ctrl,
   input  logic [olst_pkg::VALUE_WIDTH-1:0] value,
   input  logic [olst_pkg::VALUE_WIDTH-1:0] prev_entry,
   input  logic [olst_pkg::VALUE_WIDTH-1:0] next_entry,
   output logic [olst_pkg::VALUE_WIDTH-1:0] entry,
   output logic                           match
);
   import olst_pkg::*;

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                   match_ff, match_in;

   // Entry update
   always_comb begin
      case (ctrl.op)
         CELL_LOAD: entry_in = value;
         CELL_PREV: entry_in = prev_entry;
         CELL_NEXT: entry_in = next_entry;
         default:   entry_in = entry_ff;
      endcase
   end

   // Compare against the held command value, occupied cells only
   assign match_in = ctrl.occ && (entry_ff == value);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

>>> sv/ordered_list_engine.sv
// Top level of the ordered list engine: command FSM, cell chain, match
// priority groups and result registers. Depends on olst_pkg and olst_cell.
//
// A command is taken when start is high and busy is low. Every command,
// whatever its action, runs the same sequence from accept to the next
// accept: all cells compare their entry with the value (ST_CMP), match
// flags are reduced in groups of eight cells (ST_GRP), the shift is applied
// across the chain and the length updated (ST_EXEC), and then the result is
// out and a new command can be taken. The single result appears with
// rsp_valid high for exactly one cycle, the cycle in which busy falls; it
// is not held, so the receiver must take it then. The list is empty after
// reset and no clearing pass is needed.
module ordered_list_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [olst_pkg::ACT_W-1:0]  req_action,
   input  logic [olst_pkg::REQ_W-1:0]  req_value,
   input  logic [olst_pkg::POS_W-1:0]  req_position,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [olst_pkg::STAT_W-1:0] rsp_status,
   output logic [olst_pkg::LEN_W-1:0]  rsp_length
);
   import olst_pkg::*;

   // Control and command registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ACT_W-1:0]       action_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [POS_W-1:0]       pos_ff;

   // Result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [STAT_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]       rsp_length_ff, rsp_length_in;

   // Cell chain and match reduction
   logic [VALUE_WIDTH-1:0] entry_w [CAPACITY];
   logic [NGRP*GRP_SIZE-1:0] match_pad;
   logic [NGRP-1:0]        grp_any_ff, grp_any_in;
   logic [NGRP-1:0]        grp_pre;
   logic                   hit_any;

   // Command decode
   logic                   accept;
   logic                   is_ins, pos_bad, full, ins_ok, del_ok, exec;
   logic [CNT_W-1:0]       ins_pos;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign exec   = (state_ff == ST_EXEC);

   // Sequencer: compare, reduce, apply
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = start ? ST_CMP : ST_IDLE;
         ST_CMP:  state_in = ST_GRP;
         ST_GRP:  state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Group match flags and earlier-group prefix
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = |match_pad[g*GRP_SIZE +: GRP_SIZE];
      end
   end

   always_comb begin
      grp_pre[0] = 1'b0;
      for (int g = 1; g < NGRP; g++) begin
         grp_pre[g] = grp_pre[g-1] | grp_any_ff[g-1];
      end
   end

   assign hit_any = |grp_any_ff;

   // Insert / delete decisions
   always_comb begin
      is_ins  = (action_ff == ACT_HEAD) || (action_ff == ACT_TAIL) ||
                (action_ff == ACT_POS);
      pos_bad = (action_ff == ACT_POS) &&
                (WIDE_W'(pos_ff) > WIDE_W'(count_ff));
      full    = (count_ff >= CNT_W'(CAPACITY));
      ins_ok  = is_ins && !pos_bad && !full;
      del_ok  = (action_ff == ACT_DEL) && hit_any;
      case (action_ff)
         ACT_HEAD: ins_pos = '0;
         ACT_TAIL: ins_pos = count_ff;
         default:  ins_pos = CNT_W'(pos_ff);
      endcase
   end

   // Count and result
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      if (exec) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = 1'b0;
         rsp_status_in = STAT_OK;
         if (ins_ok) begin
            count_in = count_ff + 1'b1;
         end else if (del_ok) begin
            count_in = count_ff - 1'b1;
         end else if (action_ff == ACT_CLEAR) begin
            count_in = '0;
         end
         if (pos_bad) begin
            rsp_status_in = STAT_POS;
         end else if (is_ins && full) begin
            rsp_status_in = STAT_FULL;
         end else if ((action_ff == ACT_DEL) || (action_ff == ACT_FIND)) begin
            rsp_found_in  = hit_any;
            rsp_status_in = hit_any ? STAT_OK : STAT_MISS;
         end
         rsp_length_in = LEN_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff  <= held_value(req_value);
         pos_ff    <= req_position;
      end
      grp_any_ff    <= grp_any_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   // Padding of the last match group
   for (genvar p = CAPACITY; p < NGRP*GRP_SIZE; p++) begin : g_pad
      assign match_pad[p] = 1'b0;
   end

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int G = i / GRP_SIZE;
      cell_ctrl_type          ctrl;
      logic                   pre_incl;
      logic [VALUE_WIDTH-1:0] prev_e, next_e;

      // First match at or before this cell
      assign pre_incl = grp_pre[G] | (|match_pad[i:G*GRP_SIZE]);

      if (i == 0) begin : g_head
         assign prev_e = entry_w[0];
      end else begin : g_mid
         assign prev_e = entry_w[i-1];
      end
      if (i == CAPACITY-1) begin : g_last
         assign next_e = entry_w[i];
      end else begin : g_body
         assign next_e = entry_w[i+1];
      end

      always_comb begin
         ctrl.occ = (CNT_W'(i) < count_ff);
         ctrl.op  = CELL_HOLD;
         if (exec && ins_ok) begin
            if (CNT_W'(i) == ins_pos) begin
               ctrl.op = CELL_LOAD;
            end else if (CNT_W'(i) > ins_pos) begin
               ctrl.op = CELL_PREV;
            end
         end else if (exec && del_ok && pre_incl) begin
            ctrl.op = CELL_NEXT;
         end
      end

      olst_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .value      (value_ff),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .entry      (entry_w[i]),
         .match      (match_pad[i])
      );
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

`ifndef SYNTH
   // A result only follows the apply cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without apply cycle");

   // Length never exceeds the list size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // An accepted command makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accept");

   // A match is only reported with an ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == STAT_OK)
      else $error("found with non-ok status");
`endif

endmodule
